/* hdl/ip_address_text_parser_macros.svh */
`ifndef IP_ADDRESS_TEXT_PARSER_MACROS_SVH
`define IP_ADDRESS_TEXT_PARSER_MACROS_SVH

// concurrent check on clk_i, quiet while rst_ni is low
`define IPP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ip address parser check failed");

// antecedent in one cycle, consequent in the next
`define IPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ip address parser check failed");

`endif

/* hdl/ipp_pkg.sv */
`timescale 1ns / 1ps

package ipp_pkg;

  localparam int unsigned NumGroups = 8;

  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChPercent = 8'h25;

  localparam logic [8:0] OctSat        = 9'd256;
  localparam logic [2:0] DigitSat      = 3'd7;
  localparam logic [2:0] HexDigits     = 3'd4;
  localparam logic [3:0] MaxGroups     = 4'd8;
  localparam logic [3:0] MaxGapGroups  = 4'd7;
  localparam logic [3:0] MaxQuadStart  = 4'd6;
  localparam logic [1:0] QuadDots      = 2'd3;

  typedef logic [NumGroups-1:0][15:0] grp_arr_t;

  typedef struct packed {
    logic lead;
    logic aftergap;
    logic prevcol;
    logic alpha;
    logic err;
    logic scope;
    logic gap;
    logic colon;
  } flags_t;

  typedef struct packed {
    grp_arr_t    groups;
    logic [3:0]  gbg;
    logic [3:0]  gtot;
    logic [15:0] hex;
    logic [2:0]  dcnt;
    logic [8:0]  oct;
    logic [23:0] dotv;
    logic [1:0]  dots;
    logic [31:0] scope;
    flags_t      flags;
  } state_t;

  typedef struct packed {
    logic        ok;
    grp_arr_t    groups;
    logic [3:0]  total;
  } close_t;

  typedef struct packed {
    logic        valid;
    logic        v6;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] scope;
  } res_t;

  function automatic logic quad_ok(input state_t s);
    return (s.dots == QuadDots) && (s.dcnt != 3'd0) && !s.flags.alpha && !s.oct[8];
  endfunction

  // closes the final ipv6 token: a hex group, an embedded dotted quad or nothing after "::"
  function automatic close_t close_final(input state_t s, input logic after_gap);
    close_t      r;
    logic [31:0] v;
    r.ok     = 1'b0;
    r.groups = s.groups;
    r.total  = s.gtot;
    v        = {s.dotv, s.oct[7:0]};
    if (s.dcnt == 3'd0 && s.dots == 2'd0) begin
      r.ok = after_gap;
    end else if (s.dots != 2'd0) begin
      if (quad_ok(s) && s.gtot <= MaxQuadStart) begin
        r.groups[s.gtot[2:0]]                = v[31:16];
        r.groups[3'(s.gtot[2:0] + 3'd1)]     = v[15:0];
        r.total                              = 4'(s.gtot + 4'd2);
        r.ok                                 = 1'b1;
      end
    end else if (s.dcnt <= HexDigits && s.gtot < MaxGroups) begin
      r.groups[s.gtot[2:0]] = s.hex;
      r.total               = 4'(s.gtot + 4'd1);
      r.ok                  = 1'b1;
    end
    return r;
  endfunction

endpackage

/* hdl/ip_address_text_parser.sv */
`timescale 1ns / 1ps
// ip address text parser: one character beat in per cycle, sustained, with tready high
// path: input register, then the step stage, then the result register driving m_axis
// throughput: one character per cycle with tready high, via the single step stage
// reset: rst_ni async active low empties both registers and clears the parse state
// parse state also clears after every last character, ready for the next string

`include "ip_address_text_parser_macros.svh"

module ip_address_text_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  // character stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] character
  input  logic         s_axis_tlast,  // last character of the string
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,  // [63:0] address_high, [127:64] address_low,
                                      // [159:128] scope_id
  output logic [1:0]   m_axis_tuser   // [0] valid_res, [1] is_ipv6
);
  import ipp_pkg::*;

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // parse state and result register
  state_t st_q, st_d;
  state_t st_step;
  res_t   res_fin;
  res_t   res_q;
  logic   m_vld_q, m_vld_d;

  // the input stage moves on unless a last character meets a full, stalled result register
  logic adv;
  logic fin;

  assign adv = in_vld_q && (!in_last_q || !m_vld_q || m_axis_tready);
  assign fin = adv && in_last_q;

  assign s_axis_tready = !in_vld_q || adv;

  ipp_step u_step (
    .st_i   (st_q),
    .char_i (in_char_q),
    .st_o   (st_step)
  );

  // result is built from the state as it stands after the last character
  ipp_final u_final (
    .st_i  (st_step),
    .res_o (res_fin)
  );

  always_comb begin
    in_vld_d = s_axis_tready ? s_axis_tvalid : in_vld_q;
    if (fin) begin
      st_d = '0;
    end else if (adv) begin
      st_d = st_step;
    end else begin
      st_d = st_q;
    end
    if (fin) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      m_vld_d = 1'b0;
    end else begin
      m_vld_d = m_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      m_vld_q  <= 1'b0;
      st_q     <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      m_vld_q  <= m_vld_d;
      st_q     <= st_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (fin) begin
      res_q <= res_fin;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {res_q.scope, res_q.lo, res_q.hi};
  assign m_axis_tuser  = {res_q.v6, res_q.valid};

  // a result beat only appears after a last character went through the step stage
  `IPP_ASSERT(a_rise_after_last, $rose(m_axis_tvalid) |-> $past(fin))
  // a rejected string carries an all-zero payload
  `IPP_ASSERT(a_bad_zero, m_axis_tvalid && !m_axis_tuser[0] |-> !(m_axis_tuser[1] || |m_axis_tdata))
  // parse state starts clean for the next string
  `IPP_ASSERT_NEXT(a_clear_after_last, fin, st_q == '0)
  // a held character is neither dropped nor overwritten
  `IPP_ASSERT_NEXT(a_hold_input, in_vld_q && !adv, in_vld_q && $stable(in_char_q))

endmodule

/* hdl/ipp_step.sv */
`timescale 1ns / 1ps

module ipp_step (
  input  ipp_pkg::state_t st_i,
  input  logic [7:0]      char_i,
  output ipp_pkg::state_t st_o
);
  import ipp_pkg::*;

  logic        is_dec;
  logic        is_alpha;
  logic [3:0]  dval;
  logic [11:0] oct_mul;
  logic [31:0] scope_mul;
  close_t      cf;

  assign is_dec   = (char_i >= "0") && (char_i <= "9");
  assign is_alpha = ((char_i >= "a") && (char_i <= "f")) ||
                    ((char_i >= "A") && (char_i <= "F"));
  assign dval     = is_dec ? char_i[3:0] : 4'(char_i[3:0] + 4'd9);
  assign oct_mul  = ({3'b0, st_i.oct} << 3) + ({3'b0, st_i.oct} << 1) + {8'b0, dval};
  assign scope_mul = (st_i.scope << 3) + (st_i.scope << 1) + {28'b0, dval};
  assign cf       = close_final(st_i, st_i.flags.aftergap);

  always_comb begin
    st_o = st_i;
    if (!st_i.flags.err) begin
      if (st_i.flags.scope) begin
        if (is_dec) begin
          st_o.scope = scope_mul;
          if (st_i.dcnt < DigitSat) st_o.dcnt = 3'(st_i.dcnt + 3'd1);
        end else begin
          st_o.flags.err = 1'b1;
        end
      end else if (char_i == ChColon) begin
        if (st_i.flags.aftergap) begin
          st_o.flags.err = 1'b1;
        end else if (st_i.flags.prevcol) begin
          if (st_i.flags.gap) begin
            st_o.flags.err = 1'b1;
          end else begin
            st_o.flags.gap      = 1'b1;
            st_o.flags.aftergap = 1'b1;
            st_o.flags.prevcol  = 1'b0;
            st_o.flags.lead     = 1'b0;
            st_o.flags.colon    = 1'b1;
            st_o.gbg            = st_i.gtot;
          end
        end else if (st_i.dcnt == 3'd0 && st_i.dots == 2'd0) begin
          // leading colon, must be followed by another
          st_o.flags.prevcol = 1'b1;
          st_o.flags.lead    = 1'b1;
          st_o.flags.colon   = 1'b1;
        end else if (st_i.dots != 2'd0 || st_i.dcnt > HexDigits || st_i.gtot >= MaxGroups) begin
          st_o.flags.err = 1'b1;
        end else begin
          st_o.groups[st_i.gtot[2:0]] = st_i.hex;
          st_o.gtot          = 4'(st_i.gtot + 4'd1);
          st_o.hex           = '0;
          st_o.dcnt          = '0;
          st_o.oct           = '0;
          st_o.dotv          = '0;
          st_o.dots          = '0;
          st_o.flags.alpha   = 1'b0;
          st_o.flags.prevcol = 1'b1;
          st_o.flags.colon   = 1'b1;
        end
      end else if (st_i.flags.lead) begin
        st_o.flags.err = 1'b1;
      end else begin
        st_o.flags.prevcol  = 1'b0;
        st_o.flags.aftergap = 1'b0;
        if (char_i == ChPercent) begin
          if (!st_i.flags.colon || !cf.ok) begin
            st_o.flags.err = 1'b1;
          end else begin
            st_o.groups      = cf.groups;
            st_o.gtot        = cf.total;
            st_o.flags.scope = 1'b1;
            st_o.dcnt        = '0;
          end
        end else if (char_i == ChDot) begin
          if (st_i.flags.alpha || st_i.dcnt == 3'd0 || st_i.oct[8] || st_i.dots == QuadDots) begin
            st_o.flags.err = 1'b1;
          end else begin
            st_o.dotv = {st_i.dotv[15:0], st_i.oct[7:0]};
            st_o.dots = 2'(st_i.dots + 2'd1);
            st_o.oct  = '0;
            st_o.dcnt = '0;
            st_o.hex  = '0;
          end
        end else if (is_dec || is_alpha) begin
          if (is_dec) begin
            st_o.oct = (oct_mul > 12'd255) ? OctSat : oct_mul[8:0];
          end else begin
            st_o.flags.alpha = 1'b1;
          end
          if (st_i.dcnt < HexDigits) st_o.hex = {st_i.hex[11:0], dval};
          if (st_i.dcnt < DigitSat) st_o.dcnt = 3'(st_i.dcnt + 3'd1);
        end else begin
          st_o.flags.err = 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/ipp_final.sv */
`timescale 1ns / 1ps

module ipp_final (
  input  ipp_pkg::state_t st_i,
  output ipp_pkg::res_t   res_o
);
  import ipp_pkg::*;

  close_t      cf;
  grp_arr_t    grp;
  grp_arr_t    g;
  logic [3:0]  tot;
  logic [3:0]  left;
  logic [3:0]  right;
  logic        fin_ok;
  logic        shape_ok;
  logic        v6_ok;
  logic        v4_ok;
  logic [63:0] hi;
  logic [63:0] lo;

  assign cf = close_final(st_i, st_i.flags.aftergap);

  always_comb begin
    if (st_i.flags.scope) begin
      grp    = st_i.groups;
      tot    = st_i.gtot;
      fin_ok = st_i.dcnt != 3'd0;
    end else begin
      grp    = cf.groups;
      tot    = cf.total;
      fin_ok = cf.ok;
    end
    if (st_i.flags.gap) begin
      left     = st_i.gbg;
      shape_ok = (tot <= MaxGapGroups) && (st_i.gbg <= tot);
    end else begin
      left     = tot;
      shape_ok = tot == MaxGroups;
    end
    right = 4'(tot - left);
    // groups after the gap slide to the tail, the gap fills with zero
    for (int i = 0; i < NumGroups; i++) begin
      if (4'(i) < left) begin
        g[i] = grp[i];
      end else if ((5'(i) + {1'b0, right}) >= 5'd8) begin
        g[i] = grp[3'(3'(i) + tot[2:0])];
      end else begin
        g[i] = '0;
      end
    end
    hi    = {g[0], g[1], g[2], g[3]};
    lo    = {g[4], g[5], g[6], g[7]};
    v6_ok = !st_i.flags.err && st_i.flags.colon && fin_ok && shape_ok;
    v4_ok = !st_i.flags.err && !st_i.flags.colon && quad_ok(st_i);

    res_o.valid = v6_ok || v4_ok;
    res_o.v6    = v6_ok;
    res_o.hi    = v6_ok ? hi : '0;
    if (v6_ok) begin
      res_o.lo = lo;
    end else if (v4_ok) begin
      res_o.lo = {32'b0, st_i.dotv, st_i.oct[7:0]};
    end else begin
      res_o.lo = '0;
    end
    res_o.scope = v6_ok ? st_i.scope : '0;
  end

endmodule

/* dv/ip_address_text_parser_test.sv */
`timescale 1ns / 1ps

module ip_address_text_parser_test;
  import ipp_pkg::*;

  localparam int ClkPeriod   = 12;
  localparam int CycleLimit  = 200000;
  localparam int RandomChars = 600;
  localparam int HoldCycles  = 300;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // [7:0] character
  logic         s_axis_tlast;   // last character of the string
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [159:0] m_axis_tdata;   // [63:0] address_high, [127:64] address_low, [159:128] scope_id
  logic [1:0]   m_axis_tuser;   // [0] valid_res, [1] is_ipv6

  ip_address_text_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // shared bench state
  res_t        pending_results[$];
  logic [7:0]  text_q[$];
  string       noise_chars = "0123456789abcdefABCDEF:.% +-";
  int          n_errors;
  int          n_sent;       // character beats taken by the parser
  int          cycle_count;
  bit          src_gaps;
  bit          snk_gaps;
  bit          hold_req;

  // parser state mirror
  logic [15:0] grp_mem [NumGroups];
  int          gap_pos;      // groups stored when "::" was seen
  int          n_groups;
  logic [15:0] hex_acc;
  int          n_digits;
  int          octet_acc;
  logic [31:0] quad_acc;
  int          n_dots;
  logic [31:0] scope_acc;
  bit          seen_colon;
  bit          in_gap;
  bit          in_scope;
  bit          parse_bad;
  bit          has_alpha;
  bit          prev_colon;
  bit          just_gap;
  bit          lead_colon;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // parser mirror
  // ---------------------------------------------------------------------------

  function automatic void clear_token();
    hex_acc   = '0;
    n_digits  = 0;
    octet_acc = 0;
    quad_acc  = '0;
    n_dots    = 0;
    has_alpha = 1'b0;
  endfunction

  function automatic void clear_parse();
    foreach (grp_mem[i]) grp_mem[i] = '0;
    clear_token();
    gap_pos    = 0;
    n_groups   = 0;
    scope_acc  = '0;
    seen_colon = 1'b0;
    in_gap     = 1'b0;
    in_scope   = 1'b0;
    parse_bad  = 1'b0;
    prev_colon = 1'b0;
    just_gap   = 1'b0;
    lead_colon = 1'b0;
  endfunction

  function automatic bit push_group(logic [15:0] g);
    if (n_groups >= MaxGroups) return 1'b0;
    grp_mem[n_groups] = g;
    n_groups++;
    return 1'b1;
  endfunction

  function automatic bit quad_good();
    return n_dots == QuadDots && n_digits > 0 && !has_alpha && octet_acc <= 255;
  endfunction

  // closes the token that ends an ipv6 string, at '%' or at the last character
  function automatic bit close_tail(bit after_gap);
    logic [31:0] v;
    if (n_digits == 0 && n_dots == 0) return after_gap;
    if (n_dots > 0) begin
      if (!quad_good() || n_groups > MaxQuadStart) return 1'b0;
      v = {quad_acc[23:0], octet_acc[7:0]};
      void'(push_group(v[31:16]));
      void'(push_group(v[15:0]));
      return 1'b1;
    end
    if (n_digits > HexDigits) return 1'b0;
    return push_group(hex_acc);
  endfunction

  function automatic void parse_char(logic [7:0] c);
    bit b_colon;
    bit b_gap;
    bit b_prev;
    bit b_after;
    bit b_lead;
    int d;
    b_colon = seen_colon;
    b_gap   = in_gap;
    b_prev  = prev_colon;
    b_after = just_gap;
    b_lead  = lead_colon;
    // scope digits only, anything else spoils the string
    if (in_scope) begin
      if (c >= "0" && c <= "9") begin
        scope_acc = scope_acc * 32'd10 + 32'(c - "0");
        if (n_digits < DigitSat) n_digits++;
      end else begin
        parse_bad = 1'b1;
      end
      return;
    end
    if (c == ChColon) begin
      if (b_after) begin
        parse_bad = 1'b1;
      end else if (b_prev) begin
        if (b_gap) begin
          parse_bad = 1'b1;
          return;
        end
        in_gap     = 1'b1;
        just_gap   = 1'b1;
        prev_colon = 1'b0;
        lead_colon = 1'b0;
        gap_pos    = n_groups;
      end else if (n_digits == 0 && n_dots == 0) begin
        // colon at the very start of the string
        prev_colon = 1'b1;
        lead_colon = 1'b1;
      end else begin
        if (n_dots > 0 || n_digits > HexDigits || !push_group(hex_acc)) begin
          parse_bad = 1'b1;
          return;
        end
        clear_token();
        prev_colon = 1'b1;
      end
      seen_colon = 1'b1;
      return;
    end
    if (b_lead) begin
      parse_bad = 1'b1;
      return;
    end
    prev_colon = 1'b0;
    just_gap   = 1'b0;
    if (c == ChPercent) begin
      if (!b_colon || !close_tail(b_after)) begin
        parse_bad = 1'b1;
        return;
      end
      in_scope = 1'b1;
      n_digits = 0;
      return;
    end
    if (c == ChDot) begin
      if (has_alpha || n_digits == 0 || octet_acc > 255 || n_dots >= QuadDots) begin
        parse_bad = 1'b1;
        return;
      end
      quad_acc  = {quad_acc[23:0], octet_acc[7:0]};
      n_dots++;
      octet_acc = 0;
      n_digits  = 0;
      hex_acc   = '0;
      return;
    end
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      octet_acc = octet_acc * 10 + d;
      if (octet_acc > 255) octet_acc = OctSat;
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 10;
      has_alpha = 1'b1;
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 10;
      has_alpha = 1'b1;
    end else begin
      parse_bad = 1'b1;
      return;
    end
    if (n_digits < HexDigits) hex_acc = {hex_acc[11:0], 4'(d)};
    if (n_digits < DigitSat) n_digits++;
  endfunction

  // feeds one character, returns 1 with the address result on the last one
  function automatic bit predict_address(input logic [7:0] c, input bit is_last,
                                         output res_t r);
    int          total;
    int          n_left;
    int          n_right;
    logic [15:0] g [8];
    bit          ok;
    r  = '0;
    ok = 1'b0;
    if (!parse_bad) parse_char(c);
    if (!is_last) return 1'b0;
    if (!parse_bad) begin
      if (seen_colon) begin
        if (in_scope) ok = n_digits > 0;
        else ok = close_tail(just_gap);
        if (ok) begin
          total = n_groups;
          if (in_gap) begin
            n_left = gap_pos;
            ok     = total <= MaxGapGroups && n_left <= total;
          end else begin
            n_left = total;
            ok     = total == MaxGroups;
          end
          if (ok) begin
            n_right = total - n_left;
            for (int i = 0; i < 8; i++) begin
              if (i < n_left) g[i] = grp_mem[i];
              else if (i >= 8 - n_right) g[i] = grp_mem[(i - (8 - total)) & 7];
              else g[i] = '0;
            end
            r.hi    = {g[0], g[1], g[2], g[3]};
            r.lo    = {g[4], g[5], g[6], g[7]};
            r.v6    = 1'b1;
            r.scope = scope_acc;
          end
        end
      end else if (quad_good()) begin
        ok   = 1'b1;
        r.lo = {32'd0, quad_acc[23:0], octet_acc[7:0]};
      end
    end
    if (!ok) r = '0;
    r.valid = ok;
    clear_parse();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // text builders
  // ---------------------------------------------------------------------------

  function automatic void put_char(logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  function automatic void put_dec(logic [31:0] v);
    put_str($sformatf("%0d", v));
  endfunction

  function automatic void put_hexdig(int d);
    if (d < 10) put_char(8'("0" + d));
    else if ($urandom_range(0, 1)) put_char(8'("a" + d - 10));
    else put_char(8'("A" + d - 10));
  endfunction

  // mostly 1 to 4 digits, now and then too many
  function automatic void put_group();
    int n;
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    repeat (n) put_hexdig($urandom_range(0, 15));
  endfunction

  function automatic void put_octet();
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 255;
      2:       v = $urandom_range(256, 999);
      default: v = $urandom_range(0, 255);
    endcase
    if ($urandom_range(0, 7) == 0) put_str("0");
    put_dec(v);
  endfunction

  function automatic void put_quad(int n_octets);
    for (int k = 0; k < n_octets; k++) begin
      if (k != 0) put_char(ChDot);
      put_octet();
    end
  endfunction

  function automatic void build_ipv4();
    put_quad(($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 4);
  endfunction

  function automatic void build_ipv6();
    bit tail;
    int slots;
    int n;
    int n_left;
    tail  = ($urandom_range(0, 3) == 0);
    slots = tail ? 6 : 8;
    if ($urandom_range(0, 2) != 0) begin
      n = ($urandom_range(0, 15) == 0) ? slots : $urandom_range(0, slots - 1);
      n_left = $urandom_range(0, n);
      for (int k = 0; k < n_left; k++) begin
        if (k != 0) put_char(ChColon);
        put_group();
      end
      put_str("::");
      for (int k = 0; k < n - n_left; k++) begin
        if (k != 0) put_char(ChColon);
        put_group();
      end
      if (tail) begin
        if (n - n_left > 0) put_char(ChColon);
        put_quad(4);
      end
    end else begin
      n = slots;
      if ($urandom_range(0, 11) == 0) n = $urandom_range(0, 1) ? slots + 1 : slots - 1;
      for (int k = 0; k < n; k++) begin
        if (k != 0) put_char(ChColon);
        put_group();
      end
      if (tail) begin
        put_char(ChColon);
        put_quad(4);
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      put_char(ChPercent);
      if ($urandom_range(0, 19) != 0) put_dec($urandom);
      if ($urandom_range(0, 2) == 0) put_dec($urandom_range(0, 99));
    end
  endfunction

  function automatic logic [7:0] noise_char();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return noise_chars[$urandom_range(0, noise_chars.len() - 1)];
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(1, 10)) put_char(noise_char());
  endfunction

  // one replaced, inserted or dropped character
  function automatic void mutate_text();
    int pos;
    pos = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 2))
      0:       text_q[pos] = noise_char();
      1:       text_q.insert(pos, noise_char());
      default: if (text_q.size() > 1) text_q.delete(pos);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // character stream driver
  // ---------------------------------------------------------------------------

  task automatic send_char(input logic [7:0] c, input bit is_last);
    int   gap;
    res_t r;
    gap = src_gaps ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    if (predict_address(c, is_last, r)) pending_results.insert(pending_results.size(), r);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic send_string(string s);
    put_str(s);
    send_text();
  endtask

  // ---------------------------------------------------------------------------
  // result stream sink and checker
  // ---------------------------------------------------------------------------

  initial begin
    int w;
    int hold_count;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      // long hold-off so the parser backs up into its input
      if (hold_req) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        for (hold_count = 1; hold_count < HoldCycles; hold_count++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      w = snk_gaps ? $urandom_range(0, 8) : 0;
      repeat (w) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual tuser %b tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("valid_res", want.valid, m_axis_tuser[0]);
        check_field("is_ipv6", want.v6, m_axis_tuser[1]);
        check_field("address_high", want.hi, m_axis_tdata[63:0]);
        check_field("address_low", want.lo, m_axis_tdata[127:64]);
        check_field("scope_id", want.scope, m_axis_tdata[159:128]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_ipv4_forms();
    send_string("0.0.0.0");
    send_string("255.255.255.255");
    send_string("00255.1.2.3");
    send_string("256.1.1.1");
    send_string("1.2.3");
  endtask

  task automatic test_ipv6_forms();
    send_string("::");
    send_string("::1");
    send_string("1::");
    send_string("ffff:FFFF:0:1:2:3:4:5");
    send_string("::ffff:10.0.0.1");
    send_string("1:2:3:4:5:6:1.2.3.4");
    // scope wraps past 2^32
    send_string("fe80::1%4294967297");
  endtask

  task automatic test_malformed_text();
    send_string("1.2.3.4::1");
    send_string(":1:2:3:4:5:6:7");
    send_string("1:2:3:4:5:6:7:");
    send_string("1:::2");
    send_string("1::2::3");
    send_string("1.2.3.4%5");
    send_string("fe80::1%");
    send_string("::1%2x");
    send_string(" 1.2.3.4");
    send_string("+1.2.3.4");
    send_string("12345::");
    send_string("1:2:3:4:5:6:7:8:9");
    send_string("1::2:3:4:5:6:7:8");
    send_string("g1::");
    // lowest and highest byte values
    put_char(8'h00);
    put_char(8'hFF);
    send_text();
  endtask

  task automatic test_random_text();
    int start;
    int kind;
    start = n_sent;
    while (n_sent - start < RandomChars) begin
      if ($urandom_range(0, 39) == 0) begin
        src_gaps = $urandom_range(0, 1);
        snk_gaps = $urandom_range(0, 1);
      end
      kind = $urandom_range(0, 9);
      if (kind < 4) build_ipv6();
      else if (kind < 7) build_ipv4();
      else build_noise();
      if (kind < 7 && $urandom_range(0, 4) == 0) mutate_text();
      send_text();
    end
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
  endtask

  // sink stalls for a long stretch while short strings keep coming
  task automatic test_output_stall();
    src_gaps = 1'b0;
    hold_req = 1'b1;
    repeat (60) begin
      if ($urandom_range(0, 1)) begin
        put_group();
        put_str("::");
      end else begin
        put_hexdig($urandom_range(0, 15));
      end
      send_text();
    end
    src_gaps = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    n_errors      = 0;
    n_sent        = 0;
    src_gaps      = 1'b1;
    snk_gaps      = 1'b1;
    hold_req      = 1'b0;
    clear_parse();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_ipv4_forms();
    test_ipv6_forms();
    test_malformed_text();
    test_random_text();
    test_output_stall();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
